// File: sv/dpc_pkg.sv
// shared constants, register codes and pair tables for the detector pair coincidence block
package dpc_pkg;

    // default field widths
    localparam int ENERGY_BITS_DEF = 14;
    localparam int TIME_BITS_DEF   = 48;

    // fixed field widths and channel count
    localparam int CH_BITS     = 3;
    localparam int NUM_CH      = 8;
    localparam int KIND_BITS   = 3;
    localparam int WINDOW_BITS = 8;
    localparam int TOL_BITS    = 10;
    localparam int CFG_IDX_BITS = 3;

    // scale of the relative energy tolerance
    localparam int PERMILLE = 1000;

    // register reset values
    localparam int LOW_MIN_RST     = 143;
    localparam int LOW_MAX_RST     = 299;
    localparam int HIGH_MIN_RST    = 113;
    localparam int HIGH_MAX_RST    = 633;
    localparam int WINDOW_RST      = 5;
    localparam int TOL_RST         = 35;

    // configuration register codes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOW_MIN  = 3'd0,
        REG_LOW_MAX  = 3'd1,
        REG_HIGH_MIN = 3'd2,
        REG_HIGH_MAX = 3'd3,
        REG_WINDOW   = 3'd4,
        REG_TOL      = 3'd5
    } cfg_reg_t;

    // channel pairs, checked in this order
    localparam int NUM_PAIRS = 6;
    localparam int FIRST_ENERGY_PAIR = 4;
    localparam logic [CH_BITS-1:0] PAIR_A [NUM_PAIRS] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
    localparam logic [CH_BITS-1:0] PAIR_B [NUM_PAIRS] = '{3'd5, 3'd6, 3'd7, 3'd4, 3'd6, 3'd7};

endpackage

// File: sv/detector_pair_coincidence.sv
// detector pair coincidence finder: hit slots, group energy windows and pair checks
//
// Usage: hits of one event enter on the hit channel (hit_valid/hit_ready), one
// transfer per hit. A hit whose energy lies strictly inside its group window
// overwrites its channel slot. The hit marked last_hit closes the event: the
// six channel pairs are checked against the slots including that hit and one
// result leaves on the result channel (result_valid/result_ready); then all
// slots are cleared. Hits that are not last give no result.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and indexes beyond the list are dropped.
// A hit is captured in an input register; one slot update and pair check
// pass lies between it and the result register, which a last hit loads.
// Throughput is one hit per cycle, set by that single pass, unless a last
// hit waits on a held result.
// Reset clears all slots and both valid flags and loads the default configuration.
// When the receiver stalls, the result is held; further hits that give no
// result still flow, and a following last hit waits in the input register,
// which drops hit_ready until the held result is taken.
module detector_pair_coincidence
    import dpc_pkg::*;
#(
    parameter int ENERGY_BITS = ENERGY_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // hit channel
    input  logic                         hit_valid,
    output logic                         hit_ready,
    input  logic [CH_BITS-1:0]           hit_channel,
    input  logic [ENERGY_BITS-1:0]       hit_energy,
    input  logic [TIME_BITS-1:0]         hit_time,
    input  logic                         last_hit,
    input  logic                         gate_seen,
    // result channel
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         pair_found,
    output logic [KIND_BITS-1:0]         pair_kind,
    output logic [ENERGY_BITS-1:0]       first_energy,
    output logic [TIME_BITS-1:0]         first_time,
    output logic [ENERGY_BITS-1:0]       second_energy,
    output logic [TIME_BITS-1:0]         second_time,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [((ENERGY_BITS > TOL_BITS) ? ENERGY_BITS : TOL_BITS)-1:0] cfg_data
);

    localparam int PROD_BITS = ENERGY_BITS + TOL_BITS;

    // configuration registers
    logic [ENERGY_BITS-1:0] low_min_reg;
    logic [ENERGY_BITS-1:0] low_max_reg;
    logic [ENERGY_BITS-1:0] high_min_reg;
    logic [ENERGY_BITS-1:0] high_max_reg;
    logic [WINDOW_BITS-1:0] window_reg;
    logic [TOL_BITS-1:0]    tol_reg;

    // input register
    logic                   in_valid_reg;
    logic [CH_BITS-1:0]     in_ch_reg;
    logic [ENERGY_BITS-1:0] in_energy_reg;
    logic [TIME_BITS-1:0]   in_time_reg;
    logic                   in_last_reg;
    logic                   in_gate_reg;

    // channel slots
    logic [NUM_CH-1:0]      slot_valid_reg;
    logic [ENERGY_BITS-1:0] slot_energy_reg [NUM_CH];
    logic [TIME_BITS-1:0]   slot_time_reg   [NUM_CH];

    // result register
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [KIND_BITS-1:0]   out_kind_reg;
    logic [ENERGY_BITS-1:0] out_first_energy_reg;
    logic [TIME_BITS-1:0]   out_first_time_reg;
    logic [ENERGY_BITS-1:0] out_second_energy_reg;
    logic [TIME_BITS-1:0]   out_second_time_reg;

    // combinational signals
    logic                   advance;
    logic                   keep;
    logic [NUM_CH-1:0]      upd_valid;
    logic [ENERGY_BITS-1:0] upd_energy [NUM_CH];
    logic [TIME_BITS-1:0]   upd_time   [NUM_CH];
    logic [NUM_PAIRS-1:0]   pair_match;
    logic                   found_next;
    logic [KIND_BITS-1:0]   kind_next;
    logic [ENERGY_BITS-1:0] first_energy_next;
    logic [TIME_BITS-1:0]   first_time_next;
    logic [ENERGY_BITS-1:0] second_energy_next;
    logic [TIME_BITS-1:0]   second_time_next;

    // handshakes
    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || result_ready);
    assign hit_ready = !in_valid_reg || advance;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_min_reg  <= ENERGY_BITS'(LOW_MIN_RST);
            low_max_reg  <= ENERGY_BITS'(LOW_MAX_RST);
            high_min_reg <= ENERGY_BITS'(HIGH_MIN_RST);
            high_max_reg <= ENERGY_BITS'(HIGH_MAX_RST);
            window_reg   <= WINDOW_BITS'(WINDOW_RST);
            tol_reg      <= TOL_BITS'(TOL_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LOW_MIN:  low_min_reg  <= cfg_data[ENERGY_BITS-1:0];
                REG_LOW_MAX:  low_max_reg  <= cfg_data[ENERGY_BITS-1:0];
                REG_HIGH_MIN: high_min_reg <= cfg_data[ENERGY_BITS-1:0];
                REG_HIGH_MAX: high_max_reg <= cfg_data[ENERGY_BITS-1:0];
                REG_WINDOW:   window_reg   <= cfg_data[WINDOW_BITS-1:0];
                REG_TOL:      tol_reg      <= cfg_data[TOL_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (hit_ready)
        begin
            in_valid_reg <= hit_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (hit_valid && hit_ready)
        begin
            in_ch_reg     <= hit_channel;
            in_energy_reg <= hit_energy;
            in_time_reg   <= hit_time;
            in_last_reg   <= last_hit;
            in_gate_reg   <= gate_seen;
        end
    end

    // group energy window and slot update with the current hit
    always_comb
    begin
        if (!in_ch_reg[CH_BITS-1])
        begin
            keep = (in_energy_reg > low_min_reg) && (in_energy_reg < low_max_reg);
        end
        else
        begin
            keep = (in_energy_reg > high_min_reg) && (in_energy_reg < high_max_reg);
        end
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (keep && (in_ch_reg == CH_BITS'(c)))
            begin
                upd_valid[c]  = 1'b1;
                upd_energy[c] = in_energy_reg;
                upd_time[c]   = in_time_reg;
            end
            else
            begin
                upd_valid[c]  = slot_valid_reg[c];
                upd_energy[c] = slot_energy_reg[c];
                upd_time[c]   = slot_time_reg[c];
            end
        end
    end

    // pair checks, all six in parallel
    always_comb
    begin
        logic [ENERGY_BITS-1:0] ea;
        logic [ENERGY_BITS-1:0] eb;
        logic [ENERGY_BITS-1:0] de;
        logic [TIME_BITS-1:0]   ta;
        logic [TIME_BITS-1:0]   tb;
        logic [TIME_BITS-1:0]   dt;
        logic [PROD_BITS-1:0]   lhs;
        logic [PROD_BITS-1:0]   rhs;
        logic                   time_ok;
        logic                   energy_ok;
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            ea = upd_energy[PAIR_A[k]];
            eb = upd_energy[PAIR_B[k]];
            ta = upd_time[PAIR_A[k]];
            tb = upd_time[PAIR_B[k]];
            dt = (ta >= tb) ? (ta - tb) : (tb - ta);
            de = (ea >= eb) ? (ea - eb) : (eb - ea);
            time_ok = (dt <= TIME_BITS'(window_reg));
            lhs = PROD_BITS'(de) * PROD_BITS'(PERMILLE);
            rhs = PROD_BITS'(tol_reg) * PROD_BITS'(ea);
            energy_ok = (k < FIRST_ENERGY_PAIR) || (lhs < rhs);
            pair_match[k] = upd_valid[PAIR_A[k]] && upd_valid[PAIR_B[k]] && time_ok && energy_ok;
        end
    end

    // first matching pair, gated by the gate flag of the closing hit
    always_comb
    begin
        found_next         = 1'b0;
        kind_next          = '0;
        first_energy_next  = '0;
        first_time_next    = '0;
        second_energy_next = '0;
        second_time_next   = '0;
        if (in_gate_reg)
        begin
            for (int k = NUM_PAIRS - 1; k >= 0; k--)
            begin
                if (pair_match[k])
                begin
                    found_next         = 1'b1;
                    kind_next          = KIND_BITS'(k);
                    first_energy_next  = upd_energy[PAIR_A[k]];
                    first_time_next    = upd_time[PAIR_A[k]];
                    second_energy_next = upd_energy[PAIR_B[k]];
                    second_time_next   = upd_time[PAIR_B[k]];
                end
            end
        end
    end

    // slot valid bits, cleared at the end of each event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (advance)
        begin
            slot_valid_reg <= in_last_reg ? '0 : upd_valid;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                slot_energy_reg[c] <= upd_energy[c];
                slot_time_reg[c]   <= upd_time[c];
            end
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_found_reg         <= found_next;
            out_kind_reg          <= kind_next;
            out_first_energy_reg  <= first_energy_next;
            out_first_time_reg    <= first_time_next;
            out_second_energy_reg <= second_energy_next;
            out_second_time_reg   <= second_time_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign pair_found    = out_found_reg;
    assign pair_kind     = out_kind_reg;
    assign first_energy  = out_first_energy_reg;
    assign first_time    = out_first_time_reg;
    assign second_energy = out_second_energy_reg;
    assign second_time   = out_second_time_reg;

endmodule
